// File: hdl/selective_repeat_receive_window_top_macros.svh
// Assertion macros used by the receive window sequencer.
`ifndef SELECTIVE_REPEAT_RECEIVE_WINDOW_TOP_MACROS_SVH
`define SELECTIVE_REPEAT_RECEIVE_WINDOW_TOP_MACROS_SVH

`define SRRW_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define SRRW_ASSERT(label, prop, msg) \
   `SRRW_ASSERT_CLK(label, clock, reset, prop, msg)

`endif

// File: hdl/srrw_pkg.sv
// Types and constants of the selective-repeat receive window.
package srrw_pkg;

   localparam int WINDOW_SLOTS_DEF  = 16;
   localparam int SEGMENT_BYTES_DEF = 1000;

   localparam logic OP_SEGMENT = 1'b0;
   localparam logic OP_TICK    = 1'b1;

   localparam logic [1:0] KIND_STORE   = 2'd0;
   localparam logic [1:0] KIND_DELIVER = 2'd1;
   localparam logic [1:0] KIND_REQUEST = 2'd2;

   typedef struct packed {
      logic        operation;
      logic        is_data;
      logic [31:0] seg_offset;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  slot;
      logic [31:0] offset;
      logic [9:0]  length;
      logic        finished;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic set;
      logic clr;
   } slot_op_type;

   typedef struct packed {
      logic below;
      logic last_seg;
   } seg_stat_type;

endpackage

// File: hdl/srrw_slots.sv
// Slot-full flags of the receive ring.
module srrw_slots #(
   parameter int WINDOW_SLOTS = srrw_pkg::WINDOW_SLOTS_DEF,
   localparam int SLOT_W = $clog2(WINDOW_SLOTS)
) (
   input  logic                clock,
   input  logic                reset,
   input  srrw_pkg::slot_op_type slot_op,
   input  logic [SLOT_W-1:0]   wr_idx,
   input  logic [SLOT_W-1:0]   rd_idx,
   output logic                rd_full
);

   logic [WINDOW_SLOTS-1:0] full_ff;
   logic [WINDOW_SLOTS-1:0] full_in;

   always_comb begin
      full_in = full_ff;
      if (slot_op.set) begin
         full_in[wr_idx] = 1'b1;
      end
      if (slot_op.clr) begin
         full_in[wr_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= '0;
      end else begin
         full_ff <= full_in;
      end
   end

   assign rd_full = full_ff[rd_idx];

endmodule

// File: hdl/srrw_seg_unit.sv
// Shared segment unit: file-end compare and segment length.
module srrw_seg_unit #(
   parameter int SEGMENT_BYTES = srrw_pkg::SEGMENT_BYTES_DEF,
   localparam int LEN_W = $clog2(SEGMENT_BYTES + 1)
) (
   input  logic [32:0]            pos,
   input  logic [31:0]            total_size,
   output srrw_pkg::seg_stat_type stat,
   output logic [LEN_W-1:0]       seg_len
);

   logic [32:0] rest;

   always_comb begin
      rest          = {1'b0, total_size} - pos;
      stat.below    = pos < {1'b0, total_size};
      stat.last_seg = rest <= 33'(SEGMENT_BYTES);
      seg_len       = stat.last_seg ? rest[LEN_W-1:0] : LEN_W'(SEGMENT_BYTES);
   end

endmodule

// File: hdl/srrw_ctrl.sv
// Window sequencer: slot search, head drain, timeout scan and result staging.
`include "selective_repeat_receive_window_top_macros.svh"
module srrw_ctrl #(
   parameter int WINDOW_SLOTS  = srrw_pkg::WINDOW_SLOTS_DEF,
   parameter int SEGMENT_BYTES = srrw_pkg::SEGMENT_BYTES_DEF,
   localparam int SLOT_W = $clog2(WINDOW_SLOTS),
   localparam int LEN_W  = $clog2(SEGMENT_BYTES + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  srrw_pkg::req_type      req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output srrw_pkg::rsp_type      rsp_data,
   input  logic [31:0]            total_size,
   output srrw_pkg::slot_op_type  slot_op,
   output logic [SLOT_W-1:0]      slot_wr_idx,
   output logic [SLOT_W-1:0]      slot_rd_idx,
   input  logic                   slot_rd_full,
   output logic [32:0]            seg_pos,
   input  srrw_pkg::seg_stat_type seg_stat,
   input  logic [LEN_W-1:0]       seg_len
);

   localparam logic [32:0] SPAN = 33'(WINDOW_SLOTS * SEGMENT_BYTES);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_SLOTS - 1);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_FIND  = 6'b000010,
      ST_DRAIN = 6'b000100,
      ST_DREQ  = 6'b001000,
      ST_TICK  = 6'b010000,
      ST_FLUSH = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   logic [31:0]        off_ff, off_in;
   logic [32:0]        acc_ff, acc_in;
   logic [SLOT_W-1:0]  ptr_ff, ptr_in;
   logic [SLOT_W-1:0]  cnt_ff, cnt_in;
   logic [SLOT_W-1:0]  head_ff, head_in;
   logic [31:0]        next_ff, next_in;
   logic               pend_valid_ff, pend_valid_in;
   srrw_pkg::rsp_type  pend_ff, pend_in;
   logic               rsp_valid_ff, rsp_valid_in;
   srrw_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   logic               out_free;
   logic               can_gen;
   logic               gen;
   srrw_pkg::rsp_type  gen_data;
   logic               push;
   srrw_pkg::rsp_type  push_data;
   logic [32:0]        acc_step;
   logic [SLOT_W-1:0]  ptr_wrap;
   logic [SLOT_W-1:0]  head_wrap;
   logic               fin_now;
   logic               need_req;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign can_gen   = !pend_valid_ff || out_free;
   assign acc_step  = acc_ff + 33'(SEGMENT_BYTES);
   assign ptr_wrap  = (ptr_ff == SLOT_LAST) ? '0 : ptr_ff + 1'b1;
   assign head_wrap = (head_ff == SLOT_LAST) ? '0 : head_ff + 1'b1;
   assign fin_now   = next_ff >= total_size;
   assign need_req  = !slot_rd_full && seg_stat.below;

   assign req_ready   = (state_ff == ST_IDLE);
   assign slot_rd_idx = (state_ff == ST_DRAIN) ? head_ff : ptr_ff;
   assign seg_pos     = (state_ff == ST_DRAIN) ? {1'b0, next_ff} : acc_ff;

   always_comb begin
      state_in      = state_ff;
      off_in        = off_ff;
      acc_in        = acc_ff;
      ptr_in        = ptr_ff;
      cnt_in        = cnt_ff;
      head_in       = head_ff;
      next_in       = next_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      gen           = 1'b0;
      gen_data      = '0;
      push          = 1'b0;
      push_data     = pend_ff;
      slot_op       = '0;
      slot_wr_idx   = ptr_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               off_in = req_data.seg_offset;
               acc_in = {1'b0, next_ff};
               ptr_in = head_ff;
               cnt_in = '0;
               if (req_data.operation == srrw_pkg::OP_TICK) begin
                  state_in = ST_TICK;
               end else if (req_data.is_data) begin
                  state_in = ST_FIND;
               end
            end
         end
         ST_FIND: begin
            if ({1'b0, off_ff} < acc_ff) begin
               state_in = ST_DRAIN;
            end else if ({1'b0, off_ff} < acc_step) begin
               if (can_gen) begin
                  gen             = 1'b1;
                  gen_data.kind   = srrw_pkg::KIND_STORE;
                  gen_data.slot   = 4'(ptr_ff);
                  gen_data.offset = off_ff;
                  gen_data.finished = fin_now;
                  slot_op.set     = 1'b1;
                  state_in        = ST_DRAIN;
               end
            end else if (cnt_ff == SLOT_LAST) begin
               state_in = ST_DRAIN;
            end else begin
               acc_in = acc_step;
               ptr_in = ptr_wrap;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!seg_stat.below || !slot_rd_full) begin
               state_in = ST_FLUSH;
            end else if (can_gen) begin
               gen               = 1'b1;
               gen_data.kind     = srrw_pkg::KIND_DELIVER;
               gen_data.slot     = 4'(head_ff);
               gen_data.offset   = next_ff;
               gen_data.length   = 10'(seg_len);
               gen_data.finished = seg_stat.last_seg;
               slot_op.clr       = 1'b1;
               slot_wr_idx       = head_ff;
               head_in           = head_wrap;
               next_in           = next_ff + 32'(seg_len);
               ptr_in            = head_ff;
               acc_in            = {1'b0, next_ff} + SPAN;
               state_in          = ST_DREQ;
            end
         end
         ST_DREQ: begin
            if (!seg_stat.below) begin
               state_in = ST_DRAIN;
            end else if (can_gen) begin
               gen               = 1'b1;
               gen_data.kind     = srrw_pkg::KIND_REQUEST;
               gen_data.slot     = 4'(ptr_ff);
               gen_data.offset   = acc_ff[31:0];
               gen_data.length   = 10'(seg_len);
               gen_data.finished = fin_now;
               state_in          = ST_DRAIN;
            end
         end
         ST_TICK: begin
            if (!need_req || can_gen) begin
               if (need_req) begin
                  gen               = 1'b1;
                  gen_data.kind     = srrw_pkg::KIND_REQUEST;
                  gen_data.slot     = 4'(ptr_ff);
                  gen_data.offset   = acc_ff[31:0];
                  gen_data.length   = 10'(seg_len);
                  gen_data.finished = fin_now;
               end
               if (cnt_ff == SLOT_LAST) begin
                  state_in = ST_FLUSH;
               end else begin
                  acc_in = acc_step;
                  ptr_in = ptr_wrap;
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               push           = 1'b1;
               push_data.last = 1'b1;
               pend_valid_in  = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (gen) begin
         push          = pend_valid_ff;
         pend_in       = gen_data;
         pend_valid_in = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = push_data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         next_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         next_ff       <= next_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      off_ff      <= off_in;
      acc_ff      <= acc_in;
      ptr_ff      <= ptr_in;
      cnt_ff      <= cnt_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SRRW_ASSERT(a_idle_no_pending, (state_ff == ST_IDLE) |-> !pend_valid_ff, "pending result in idle")
   `SRRW_ASSERT(a_push_has_room, push |-> out_free, "result pushed into a full output register")
   `SRRW_ASSERT(a_deliver_bound, (state_ff == ST_DRAIN && gen) |=> (next_ff <= total_size), "delivery ran past file end")
   `SRRW_ASSERT(a_below_first, (state_ff == ST_FIND && {1'b0, off_ff} < acc_ff) |-> (cnt_ff == '0), "slot search passed the arrival")

endmodule

// File: hdl/selective_repeat_receive_window_top.sv
// Top level of the selective-repeat receive window controller.
// Usage:
//  csr_valid/csr_ready/csr_data write total_size; csr_ready is always high, write only when idle.
//  req_* carries one item per transfer: a segment arrival or a timeout tick.
//  rsp_* returns the results of that item in order; the final one carries last.
// Sequencing:
//  An arrival is accepted in IDLE, then the slot search (FIND) checks up to WINDOW_SLOTS
//  slots; each delivered head slot passes DRAIN and DREQ, and FLUSH closes the item.
//  A tick scans all WINDOW_SLOTS slots in TICK, then FLUSH; a dropped item (non-data)
//  is accepted in IDLE with no result. Results leave through a one-entry staging
//  register and an output register; a result waits in staging until the next one is
//  formed or the item closes. The shared segment-length unit is used once per cycle
//  by the sequencer. req_ready is high only between items.
// Reset:
//  Synchronous reset clears all slot flags, the head slot, the next offset and total_size.
// Stalls:
//  While rsp_ready is low the output register holds its transfer and the sequencer
//  waits once the staging register is full; no result is lost or repeated.
module selective_repeat_receive_window_top #(
   parameter int WINDOW_SLOTS  = srrw_pkg::WINDOW_SLOTS_DEF,
   parameter int SEGMENT_BYTES = srrw_pkg::SEGMENT_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [31:0]       csr_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  srrw_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output srrw_pkg::rsp_type rsp_data
);

   localparam int SLOT_W = $clog2(WINDOW_SLOTS);
   localparam int LEN_W  = $clog2(SEGMENT_BYTES + 1);

   logic [31:0]            total_size_ff, total_size_in;
   srrw_pkg::slot_op_type  slot_op;
   logic [SLOT_W-1:0]      slot_wr_idx;
   logic [SLOT_W-1:0]      slot_rd_idx;
   logic                   slot_rd_full;
   logic [32:0]            seg_pos;
   srrw_pkg::seg_stat_type seg_stat;
   logic [LEN_W-1:0]       seg_len;

   assign csr_ready     = 1'b1;
   assign total_size_in = (csr_valid && csr_ready) ? csr_data : total_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_size_ff <= '0;
      end else begin
         total_size_ff <= total_size_in;
      end
   end

   srrw_slots #(
      .WINDOW_SLOTS (WINDOW_SLOTS)
   ) u_slots (
      .clock   (clock),
      .reset   (reset),
      .slot_op (slot_op),
      .wr_idx  (slot_wr_idx),
      .rd_idx  (slot_rd_idx),
      .rd_full (slot_rd_full)
   );

   srrw_seg_unit #(
      .SEGMENT_BYTES (SEGMENT_BYTES)
   ) u_seg_unit (
      .pos        (seg_pos),
      .total_size (total_size_ff),
      .stat       (seg_stat),
      .seg_len    (seg_len)
   );

   srrw_ctrl #(
      .WINDOW_SLOTS  (WINDOW_SLOTS),
      .SEGMENT_BYTES (SEGMENT_BYTES)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .total_size   (total_size_ff),
      .slot_op      (slot_op),
      .slot_wr_idx  (slot_wr_idx),
      .slot_rd_idx  (slot_rd_idx),
      .slot_rd_full (slot_rd_full),
      .seg_pos      (seg_pos),
      .seg_stat     (seg_stat),
      .seg_len      (seg_len)
   );

endmodule
